>>> src/signed_int_to_decimal_ascii_core_assert.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_assert.svh
// Assertion macros for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SITDA_ASSERT_NOW(lbl, ante, cons, msg)
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Constants and double-dabble helpers for the decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

	localparam int BIN_W        = 32;
	localparam int NUM_DIGITS   = 10;
	localparam int BCD_W        = 4 * NUM_DIGITS;
	localparam int WORD_W       = BCD_W + BIN_W;
	localparam int DD_PER_STAGE = 8;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef logic [WORD_W-1:0] dd_word_t;
	typedef logic [BCD_W-1:0]  bcd_t;
	typedef logic [3:0]        digit_cnt_t;

	// one shift-add-3 step over the combined {bcd, binary} word
	function automatic dd_word_t dd_step(input dd_word_t w);
		dd_word_t r;
		r = w;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (r[BIN_W + 4*i +: 4] >= 4'd5) begin
				r[BIN_W + 4*i +: 4] = r[BIN_W + 4*i +: 4] + 4'd3;
			end
		end
		return {r[WORD_W-2:0], 1'b0};
	endfunction

	// the steps done by one pipeline stage
	function automatic dd_word_t dd_stage(input dd_word_t w);
		dd_word_t r;
		r = w;
		for (int s = 0; s < DD_PER_STAGE; s++) begin
			r = dd_step(r);
		end
		return r;
	endfunction

endpackage

>>> src/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per output transaction, most significant character first.
// ----------------------------------------------------------------------------
// Each input transaction carries one two's complement value. The block sends
// out '-' for a negative value, then the decimal digits without leading zeros
// (zero gives a single '0'); last is high on the final character. The most
// negative value prints as "-2147483648". Conversion runs through a six-stage
// pipeline: stage 1 takes the magnitude, stages 2 to 5 each run eight
// double-dabble shift-add-3 steps, stage 6 counts digits and left-aligns the
// BCD. An output emitter then sends one character per cycle while out_ready is
// high, so a number takes 1 to 11 characters (digit count plus one for a
// minus sign); the emitter sets the sustained rate. A new value may enter
// every cycle while the pipeline has room, and a stall anywhere backs up
// through the stages without dropping or repeating a transaction. Each value
// passes stages 1 to 6 and the emitter register before its first character.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_core_assert.svh"

module signed_int_to_decimal_ascii_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [31:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        char_out,
	output logic              last
);
	import sitda_pkg::*;

	// pipeline valid bits and payload
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic             neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [BIN_W-1:0] mag_s1;
	dd_word_t         word_s2, word_s3, word_s4, word_s5;
	bcd_t             bcd_s6;
	digit_cnt_t       ndig_s6;

	// emitter state
	logic       busy_q;
	logic       sign_q;
	digit_cnt_t rem_q;
	bcd_t       bcd_q;

	// stage-take signals: a stage loads when empty or when its content moves on
	logic take_s1, take_s2, take_s3, take_s4, take_s5, take_s6;
	logic out_fire, last_now, load_ok;

	assign out_fire = out_valid && out_ready;
	assign last_now = !sign_q && (rem_q == digit_cnt_t'(1));
	assign load_ok  = !busy_q || (out_fire && last_now);

	assign take_s6  = !v_s6 || load_ok;
	assign take_s5  = !v_s5 || take_s6;
	assign take_s4  = !v_s4 || take_s5;
	assign take_s3  = !v_s3 || take_s4;
	assign take_s2  = !v_s2 || take_s3;
	assign take_s1  = !v_s1 || take_s2;
	assign in_ready = take_s1;

	// digit count and left alignment of the finished BCD
	bcd_t       bcd_fin;
	digit_cnt_t nd;
	digit_cnt_t shamt;
	logic [5:0] bit_shamt;

	always_comb begin
		bcd_fin = word_s5[WORD_W-1:BIN_W];
		nd      = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_fin[4*i +: 4] != 4'd0) begin
				nd = digit_cnt_t'(i + 1);
			end
		end
		// zero still prints one digit
		if (nd == '0) begin
			nd = digit_cnt_t'(1);
		end
		shamt     = digit_cnt_t'(NUM_DIGITS) - nd;
		bit_shamt = {shamt, 2'b00};
	end

	// valid bits advance with their stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (take_s1) v_s1 <= in_valid;
			if (take_s2) v_s2 <= v_s1;
			if (take_s3) v_s3 <= v_s2;
			if (take_s4) v_s4 <= v_s3;
			if (take_s5) v_s5 <= v_s4;
			if (take_s6) v_s6 <= v_s5;
		end
	end

	// payload: hold while the stage is stalled
	always_ff @(posedge clk) begin
		if (take_s1) begin
			neg_s1 <= value[BIN_W-1];
			// the most negative value negates to 2^31, which fits unsigned
			mag_s1 <= value[BIN_W-1] ? (BIN_W'(0) - BIN_W'(value)) : BIN_W'(value);
		end
		if (take_s2) begin
			neg_s2  <= neg_s1;
			word_s2 <= dd_stage({BCD_W'(0), mag_s1});
		end
		if (take_s3) begin
			neg_s3  <= neg_s2;
			word_s3 <= dd_stage(word_s2);
		end
		if (take_s4) begin
			neg_s4  <= neg_s3;
			word_s4 <= dd_stage(word_s3);
		end
		if (take_s5) begin
			neg_s5  <= neg_s4;
			word_s5 <= dd_stage(word_s4);
		end
		if (take_s6) begin
			neg_s6  <= neg_s5;
			ndig_s6 <= nd;
			bcd_s6  <= bcd_fin << bit_shamt;
		end
	end

	// emitter: send sign, then one digit per transaction from the top nibble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			rem_q  <= '0;
		end else if (load_ok) begin
			busy_q <= v_s6;
			sign_q <= v_s6 && neg_s6;
			rem_q  <= v_s6 ? ndig_s6 : '0;
		end else if (out_fire) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				rem_q <= rem_q - digit_cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			bcd_q <= bcd_s6;
		end else if (out_fire && !sign_q) begin
			bcd_q <= bcd_q << 4;
		end
	end

	assign out_valid = busy_q;
	assign last      = last_now;
	assign char_out  = sign_q ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, bcd_q[BCD_W-1 -: 4]});

	// the final character of a number is always a digit
	`SITDA_ASSERT_NOW(a_last_is_digit, out_valid && last, !sign_q, "last flagged on minus sign")
	// an active emitter always has between one and ten digits to go
	`SITDA_ASSERT_NOW(a_rem_range, busy_q,
		(rem_q != '0) && (rem_q <= digit_cnt_t'(NUM_DIGITS)), "digit count out of range")
	// a number handed to the emitter shows up on the output next cycle
	`SITDA_ASSERT_NEXT(a_load_busy, v_s6 && load_ok, busy_q, "emitter dropped a number")
	// a stalled last stage holds its contents
	`SITDA_ASSERT_NEXT(a_s6_hold, v_s6 && !load_ok,
		v_s6 && $stable(ndig_s6) && $stable(neg_s6), "stage 6 lost data while stalled")

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed integer to decimal ASCII core.
// ----------------------------------------------------------------------------
// A directed table covers zero, one-digit and power-of-ten boundaries, both
// extremes and the most negative value. Random values follow in four idling
// modes. Every accepted input transaction queues the characters it should
// produce. Each output transaction is checked against the oldest queued
// character.
// ----------------------------------------------------------------------------
module testbench;

	import sitda_pkg::*;

	localparam int RANDOM_PER_MODE = 88;
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 30;
	localparam int NUM_ROWS        = 20;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [7:0] ch;
		logic       fin;
	} char_exp_t;

	// an empty text means the row is checked against the predictor
	typedef struct {
		logic signed [31:0] num;
		string              text;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         char_out;
	logic               last;

	char_exp_t  expected_chars[$];
	idle_mode_t idle_mode = IDLE_NONE;
	bit         hold_request = 1'b0;
	int         error_count = 0;
	int         quiet_cycles = 0;

	row_t directed_rows[NUM_ROWS] = '{
		'{32'sd0,           "0"},
		'{32'sd1,           "1"},
		'{-32'sd1,          "-1"},
		'{32'sd9,           "9"},
		'{32'sd10,          "10"},
		'{-32'sd10,         "-10"},
		'{32'sd99,          "99"},
		'{32'sd100,         "100"},
		'{32'sd999999999,   "999999999"},
		'{32'sd1000000000,  "1000000000"},
		'{-32'sd1000000000, "-1000000000"},
		'{32'sh7FFF_FFFF,   "2147483647"},
		'{32'sh8000_0001,   "-2147483647"},
		'{32'sh8000_0000,   "-2147483648"},
		'{32'sh5555_5555,   ""},
		'{32'shAAAA_AAAA,   ""},
		'{32'sh0F0F_0F0F,   ""},
		'{32'shF0F0_F0F0,   ""},
		'{32'sd123456789,   ""},
		'{-32'sd98765,      ""}
	};

	signed_int_to_decimal_ascii_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_out  (char_out),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queue the decimal text of v: sign first, then digits most significant
	// first, last set on the final digit.
	task automatic predict_decimal_text(input logic signed [31:0] v);
		logic [31:0] mag;
		logic [7:0]  digit_chars[10];
		int          n;
		mag = v[31] ? 32'(-v) : 32'(v);
		n = 0;
		if (v[31]) begin
			expected_chars.push_back('{CHAR_MINUS, 1'b0});
		end
		do begin
			digit_chars[n] = CHAR_ZERO + 8'(mag % 32'd10);
			mag = mag / 32'd10;
			n++;
		end while (mag != 0);
		for (int i = n - 1; i >= 0; i--) begin
			expected_chars.push_back('{digit_chars[i], i == 0});
		end
	endtask

	// Queue a text typed in by hand.
	task automatic expect_text(input string text);
		for (int i = 0; i < text.len(); i++) begin
			expected_chars.push_back('{8'(text[i]), i == text.len() - 1});
		end
	endtask

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 80;
			IDLE_BOTH:   return $urandom_range(99) < 22;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(99) < 80;
			IDLE_BOTH:     return $urandom_range(99) < 22;
			default:       return 1'b0;
		endcase
	endfunction

	// Mix raw words, small numbers, numbers of a chosen digit count and
	// values right at a power of ten.
	function automatic logic signed [31:0] pick_value();
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned p;
		longint unsigned mag;
		int              k;
		logic signed [31:0] v;
		case ($urandom_range(3))
			0: return $urandom;
			1: mag = $urandom_range(200);
			2: begin
				k = $urandom_range(1, 10);
				p = 1;
				for (int i = 1; i < k; i++) p = p * 10;
				lo = (k == 1) ? 0 : p;
				hi = p * 10 - 1;
				if (hi > 64'd2147483648) hi = 64'd2147483648;
				mag = lo + {$urandom, $urandom} % (hi - lo + 1);
			end
			default: begin
				k = $urandom_range(9);
				p = 1;
				for (int i = 0; i < k; i++) p = p * 10;
				mag = p + $urandom_range(2) - 1;
			end
		endcase
		v = mag[31:0];
		return $urandom_range(1) ? -v : v;
	endfunction

	// Offer one value and return in the time step it is accepted.
	task automatic offer_value(input logic signed [31:0] v);
		while (sender_idles()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic check_char();
		char_exp_t exp_c;
		if (expected_chars.size() == 0) begin
			$error("unexpected character transaction: char_out=%h last=%b", char_out, last);
			error_count++;
		end else begin
			exp_c = expected_chars.pop_front();
			if (char_out !== exp_c.ch) begin
				$error("char_out mismatch: expected %h, actual %h", exp_c.ch, char_out);
				error_count++;
			end
			if (last !== exp_c.fin) begin
				$error("last mismatch: expected %b, actual %b", exp_c.fin, last);
				error_count++;
			end
		end
	endtask

	// Receiver: check each character transaction, then pick the next
	// out_ready. A hold request blocks the output until a counter loaded from
	// HOLD_CYCLES runs out, so the pipeline fills and the input stalls.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				check_char();
			end
			if (hold_request && hold_left == 0) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !receiver_stalls();
			end
		end
	end

	// Watchdog: count cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table with no idling.
		for (int r = 0; r < NUM_ROWS; r++) begin
			offer_value(directed_rows[r].num);
			if (directed_rows[r].text.len() != 0) begin
				expect_text(directed_rows[r].text);
			end else begin
				predict_decimal_text(directed_rows[r].num);
			end
		end

		// Random values through each idling mode; block the receiver once
		// early on while the sender keeps going.
		for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
			logic signed [31:0] v;
			idle_mode = idle_mode_t'(m);
			for (int i = 0; i < RANDOM_PER_MODE; i++) begin
				if (idle_mode == IDLE_NONE && i == 10) begin
					hold_request = 1'b1;
				end
				v = pick_value();
				offer_value(v);
				predict_decimal_text(v);
			end
		end
		in_valid <= 1'b0;

		// Drain: wait for every queued character, then watch for strays.
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_chars.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/sitda_pkg.sv
src/signed_int_to_decimal_ascii_core.sv
sim/testbench.sv
